// File: design/cld_pkg.sv
// cld_pkg: shared types and constants for the bounded deque block
// operation codes, result status codes, control states and default sizes
// no dependencies
package cld_pkg;

  localparam int unsigned DefCapacity = 16;
  localparam int unsigned ValueWidth  = 32;

  typedef enum logic [2:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_DUMP       = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_OVERFLOW = 2'd1,
    STATUS_EMPTY    = 2'd2
  } status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_DUMP = 1'b1
  } state_e;

endpackage

// File: design/cld_ram.sv
// cld_ram: generic single write port, single read port memory
// registered read; no dependencies
module cld_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/circular_list_deque.sv
// circular_list_deque: bounded double-ended queue over a ring memory
// pushes and pops: one word per cycle while not busy, result in the cycle after acceptance
// dump: busy until every entry is read, one entry read per cycle from the ring memory
// results cannot be stalled; each strobe cycle carries one word
// reset clears front index, count and control; the ring contents stay unknown
// depends on cld_pkg and cld_ram
module circular_list_deque #(
  parameter int unsigned CAPACITY = cld_pkg::DefCapacity
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  kind_i,
  input  logic signed [31:0] value_i,
  output logic        strobe_o,
  output logic [1:0]  status_o,
  output logic signed [31:0] value_res_o,
  output logic        last_o
);

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned VW = cld_pkg::ValueWidth;
  localparam logic [CW:0]   CapSum  = (CW + 1)'(CAPACITY);
  localparam logic [CW-1:0] CapCnt  = CW'(CAPACITY);
  localparam logic [IW-1:0] LastIdx = IW'(CAPACITY - 1);

  // ring position of base + off, with base + off below twice the capacity
  function automatic logic [IW-1:0] wrap_add(logic [IW-1:0] base, logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW + 1)'(base) + {1'b0, off};
    if (s >= CapSum) begin
      s = s - CapSum;
    end
    return s[IW-1:0];
  endfunction

  cld_pkg::state_e state_q, state_d;
  logic [IW-1:0] front_q, front_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;

  logic                 strobe_q, strobe_d;
  cld_pkg::status_e     status_q, status_d;
  logic                 last_q, last_d;
  logic                 use_mem_q, use_mem_d;
  logic [VW-1:0]        val_q, val_d;

  logic          we, re;
  logic [IW-1:0] waddr, raddr;
  logic [VW-1:0] rdata;
  logic          accept;

  assign accept = start && (state_q == cld_pkg::ST_IDLE);
  assign busy   = (state_q != cld_pkg::ST_IDLE);

  cld_ram #(
    .Width(VW),
    .Depth(CAPACITY),
    .AddrW(IW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(value_i),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    state_d   = state_q;
    front_d   = front_q;
    count_d   = count_q;
    idx_d     = idx_q;
    strobe_d  = 1'b0;
    status_d  = cld_pkg::STATUS_OK;
    last_d    = 1'b1;
    use_mem_d = 1'b0;
    val_d     = value_i;
    we        = 1'b0;
    waddr     = front_q;
    re        = 1'b0;
    raddr     = front_q;

    case (state_q)
      cld_pkg::ST_IDLE: begin
        if (accept) begin
          case (kind_i)
            cld_pkg::KIND_PUSH_FRONT, cld_pkg::KIND_PUSH_BACK: begin
              strobe_d = 1'b1;
              if (count_q >= CapCnt) begin
                status_d = cld_pkg::STATUS_OVERFLOW;
              end else begin
                we      = 1'b1;
                count_d = count_q + 1'b1;
                if (kind_i == cld_pkg::KIND_PUSH_FRONT) begin
                  front_d = (front_q == '0) ? LastIdx : front_q - 1'b1;
                  waddr   = front_d;
                end else begin
                  waddr = wrap_add(front_q, count_q);
                end
              end
            end
            cld_pkg::KIND_POP_FRONT, cld_pkg::KIND_POP_BACK: begin
              strobe_d = 1'b1;
              if (count_q == '0) begin
                status_d = cld_pkg::STATUS_EMPTY;
                val_d    = '0;
              end else begin
                re        = 1'b1;
                use_mem_d = 1'b1;
                count_d   = count_q - 1'b1;
                if (kind_i == cld_pkg::KIND_POP_FRONT) begin
                  raddr   = front_q;
                  front_d = wrap_add(front_q, CW'(1));
                end else begin
                  raddr = wrap_add(front_q, count_q - 1'b1);
                end
              end
            end
            cld_pkg::KIND_DUMP: begin
              if (count_q == '0) begin
                strobe_d = 1'b1;
                status_d = cld_pkg::STATUS_EMPTY;
                val_d    = '0;
              end else begin
                idx_d   = '0;
                state_d = cld_pkg::ST_DUMP;
              end
            end
            default: begin
              // unknown operation: no word, no state change
            end
          endcase
        end
      end
      cld_pkg::ST_DUMP: begin
        re        = 1'b1;
        raddr     = wrap_add(front_q, idx_q);
        strobe_d  = 1'b1;
        use_mem_d = 1'b1;
        last_d    = (idx_q == count_q - 1'b1);
        idx_d     = idx_q + 1'b1;
        if (last_d) begin
          state_d = cld_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = cld_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= cld_pkg::ST_IDLE;
      front_q  <= '0;
      count_q  <= '0;
      idx_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      front_q  <= front_d;
      count_q  <= count_d;
      idx_q    <= idx_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q  <= status_d;
    last_q    <= last_d;
    use_mem_q <= use_mem_d;
    val_q     <= val_d;
  end

  // popped and dumped words come straight from the memory read register
  assign strobe_o    = strobe_q;
  assign status_o    = status_q;
  assign last_o      = last_q;
  assign value_res_o = use_mem_q ? signed'(rdata) : signed'(val_q);

endmodule

// File: sim/testbench.sv
// testbench: self-checking bench for circular_list_deque at its default capacity
// drives push, pop, dump and reserved-code words with random gaps and checks every result word
// depends on cld_pkg and the circular_list_deque design files
module testbench;
  import cld_pkg::*;

  localparam int unsigned DEPTH = DefCapacity;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam logic [2:0] KIND_RSVD_LO = 3'd5;
  localparam logic [2:0] KIND_RSVD_MID = 3'd6;
  localparam logic [2:0] KIND_RSVD_HI = 3'd7;

  typedef struct packed {
    status_e     status;
    logic [31:0] value;
    logic        last;
  } word_t;

  typedef struct {
    logic [2:0]  kind;
    logic [31:0] value;
    int          reps;
    bit          typed;
    word_t       want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic [2:0] kind_i = '0;
  logic signed [31:0] value_i = '0;
  logic busy;
  logic strobe_o;
  logic [1:0] status_o;
  logic signed [31:0] value_res_o;
  logic last_o;

  // typed expectation for the word on the inputs, replaces the prediction
  bit typed_on = 1'b0;
  word_t typed_word = '0;

  word_t pending_words[$];
  logic [31:0] ring_copy [DEPTH];
  int unsigned head_pos = 0;
  int unsigned fill_count = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  circular_list_deque dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .kind_i      (kind_i),
    .value_i     (value_i),
    .strobe_o    (strobe_o),
    .status_o    (status_o),
    .value_res_o (value_res_o),
    .last_o      (last_o)
  );

  always #1 clk_i = ~clk_i;

  task automatic flag(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  function automatic void deque_step(input logic [2:0] k, input logic [31:0] v);
    int unsigned pos;
    case (k)
      KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
        if (fill_count >= DEPTH) begin
          pending_words.push_back('{STATUS_OVERFLOW, v, 1'b1});
        end else begin
          if (k == KIND_PUSH_FRONT) begin
            head_pos = (head_pos + DEPTH - 1) % DEPTH;
            pos = head_pos;
          end else begin
            pos = (head_pos + fill_count) % DEPTH;
          end
          ring_copy[pos] = v;
          fill_count++;
          pending_words.push_back('{STATUS_OK, v, 1'b1});
        end
      end
      KIND_POP_FRONT, KIND_POP_BACK: begin
        if (fill_count == 0) begin
          pending_words.push_back('{STATUS_EMPTY, 32'd0, 1'b1});
        end else begin
          if (k == KIND_POP_FRONT) begin
            pos = head_pos;
            head_pos = (head_pos + 1) % DEPTH;
          end else begin
            pos = (head_pos + fill_count - 1) % DEPTH;
          end
          fill_count--;
          pending_words.push_back('{STATUS_OK, ring_copy[pos], 1'b1});
        end
      end
      KIND_DUMP: begin
        if (fill_count == 0) begin
          pending_words.push_back('{STATUS_EMPTY, 32'd0, 1'b1});
        end else begin
          for (int i = 0; i < fill_count; i++) begin
            pending_words.push_back('{STATUS_OK, ring_copy[(head_pos + i) % DEPTH],
                                      (i + 1 == fill_count)});
          end
        end
      end
      default: ;
    endcase
  endfunction

  // check result words, then predict the word accepted at this edge
  always @(posedge clk_i) begin
    word_t want;
    int unsigned base;
    if (rst_ni) begin
      if (strobe_o) begin
        if (pending_words.size() == 0) begin
          flag($sformatf("unexpected word status %0d value %h", status_o, value_res_o));
        end else begin
          want = pending_words.pop_front();
          if (status_o !== want.status)
            flag($sformatf("status %0d, want %0d", status_o, want.status));
          if (value_res_o !== want.value)
            flag($sformatf("value %h, want %h", value_res_o, want.value));
          if (last_o !== want.last)
            flag($sformatf("last %b, want %b", last_o, want.last));
        end
      end
      if (start && !busy) begin
        base = pending_words.size();
        deque_step(kind_i, value_i);
        if (typed_on) begin
          while (pending_words.size() > base) void'(pending_words.pop_back());
          pending_words.push_back(typed_word);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 30);
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 1) ? 32'h0 : 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] pick_push();
    return $urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
  endfunction

  function automatic logic [2:0] pick_pop();
    return $urandom_range(0, 1) ? KIND_POP_FRONT : KIND_POP_BACK;
  endfunction

  function automatic stim_row_t row(input logic [2:0] k, input logic [31:0] v, input int reps,
                                    input bit typed, input status_e st, input logic [31:0] wv);
    stim_row_t r;
    r.kind = k;
    r.value = v;
    r.reps = reps;
    r.typed = typed;
    r.want = '{st, wv, 1'b1};
    return r;
  endfunction

  // present one word after a gap and hold it until it is taken
  task automatic issue(input logic [2:0] k, input logic [31:0] v, input bit typed,
                       input word_t want, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      kind_i <= 3'($urandom);
      value_i <= $urandom;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    kind_i <= k;
    value_i <= v;
    typed_on <= typed;
    typed_word <= want;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  initial begin
    stim_row_t directed[$];
    logic [2:0] k;
    bit grow;
    bit quiet;
    int counted;

    directed.push_back(row(KIND_POP_FRONT, 32'h1111_1111, 1, 1, STATUS_EMPTY, 32'h0));
    directed.push_back(row(KIND_POP_BACK, 32'h2222_2222, 1, 1, STATUS_EMPTY, 32'h0));
    directed.push_back(row(KIND_DUMP, 32'h3333_3333, 1, 1, STATUS_EMPTY, 32'h0));
    directed.push_back(row(KIND_RSVD_LO, 32'h0000_1234, 1, 0, STATUS_OK, 32'h0));
    directed.push_back(row(KIND_RSVD_HI, 32'hffff_ffff, 1, 0, STATUS_OK, 32'h0));
    directed.push_back(row(KIND_PUSH_BACK, 32'h7fff_ffff, 1, 1, STATUS_OK, 32'h7fff_ffff));
    directed.push_back(row(KIND_PUSH_FRONT, 32'h8000_0000, 1, 1, STATUS_OK, 32'h8000_0000));
    directed.push_back(row(KIND_DUMP, 32'h0, 1, 0, STATUS_OK, 32'h0));
    directed.push_back(row(KIND_POP_BACK, 32'h0, 1, 0, STATUS_OK, 32'h0));
    directed.push_back(row(KIND_POP_FRONT, 32'h0, 1, 0, STATUS_OK, 32'h0));
    // front index wraps below zero here
    directed.push_back(row(KIND_PUSH_FRONT, 32'h0000_0000, 9, 0, STATUS_OK, 32'h0));
    directed.push_back(row(KIND_PUSH_BACK, 32'hffff_fff0, 7, 0, STATUS_OK, 32'h0));
    directed.push_back(row(KIND_PUSH_BACK, 32'hffff_ffff, 1, 1, STATUS_OVERFLOW, 32'hffff_ffff));
    directed.push_back(row(KIND_PUSH_FRONT, 32'h5555_5555, 1, 1, STATUS_OVERFLOW, 32'h5555_5555));
    directed.push_back(row(KIND_DUMP, 32'h0, 1, 0, STATUS_OK, 32'h0));
    directed.push_back(row(KIND_POP_BACK, 32'h0, 8, 0, STATUS_OK, 32'h0));
    directed.push_back(row(KIND_POP_FRONT, 32'h0, 8, 0, STATUS_OK, 32'h0));
    directed.push_back(row(KIND_POP_FRONT, 32'h0, 1, 1, STATUS_EMPTY, 32'h0));
    directed.push_back(row(KIND_RSVD_MID, 32'haaaa_aaaa, 1, 0, STATUS_OK, 32'h0));

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed[i]) begin
      for (int n = 0; n < directed[i].reps; n++) begin
        issue(directed[i].kind, directed[i].value + n, directed[i].typed,
              directed[i].want, pick_gap());
      end
    end

    // random part: fill and drain sweeps so the ring wraps and hits full and empty
    grow = 1'b1;
    quiet = 1'b0;
    counted = 0;
    while (counted < 180) begin
      if (counted % 25 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (fill_count == DEPTH && $urandom_range(0, 3) == 0) grow = 1'b0;
      if (fill_count == 0 && $urandom_range(0, 3) == 0) grow = 1'b1;
      case ($urandom_range(0, 99)) inside
        [0:3]:   k = ($urandom_range(0, 1)) ? KIND_RSVD_LO :
                     (($urandom_range(0, 1)) ? KIND_RSVD_MID : KIND_RSVD_HI);
        [4:11]:  k = KIND_DUMP;
        [12:77]: k = grow ? pick_push() : pick_pop();
        default: k = grow ? pick_pop() : pick_push();
      endcase
      if (k <= KIND_DUMP) counted++;
      issue(k, pick_value(), 1'b0, '0, quiet ? 0 : pick_gap());
    end
    start <= 1'b0;

    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: sim.f
design/cld_pkg.sv
design/cld_ram.sv
design/circular_list_deque.sv
sim/testbench.sv
